// File: sv/scrf_pkg.sv
package scrf_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_CONVERGED = 2'd0,
    STATUS_ZERO_DEN  = 2'd1,
    STATUS_LIMIT     = 2'd2
  } status_t;

  // Configuration register indexes
  localparam logic [7:0] REG_TOLERANCE  = 8'd0;
  localparam logic [7:0] REG_ITER_LIMIT = 8'd1;

  // Register widths and reset values
  localparam int TOL_W   = 31;
  localparam int LIMIT_W = 8;
  localparam logic [TOL_W-1:0]   TOL_RESET   = 31'd66;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;

  // Saturate a signed 64-bit value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: sv/secant_cubic_root_finder.sv
// Secant root finder for f(x) = x^3 - 2x - 5 in signed fixed point with FRAC_BITS fraction
// bits. A beat on s_axis carries two starting guesses; one beat on m_axis returns the root,
// a status and the iteration count. All multiplications share one 32x32 multiplier and the
// quotient comes from a radix-2 divider that retires one bit per cycle. The block accepts no
// new guesses while a search runs; a finished result waits in the output register while the
// next item is taken. Configuration writes are always accepted.
module secant_cubic_root_finder #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // s_axis_tdata: [31:0] guess_first, [63:32] guess_second
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  // m_axis_tdata: [31:0] root, [33:32] status, [41:34] iterations_used, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_CSQ, S_CCU, S_CMUL, S_CFIN, S_ITER,
    S_NUM1, S_NUM2, S_NUM3, S_DIV, S_DFIN, S_DONE
  } state_t;

  localparam logic signed [35:0] FIVE_Q = 36'sd5 <<< FRAC_BITS;

  state_t state;
  logic [scrf_pkg::TOL_W-1:0]   tolerance;
  logic [scrf_pkg::LIMIT_W-1:0] iteration_limit;

  logic signed [31:0] x1, x2, f1, f2, cx, sq, den;
  logic signed [63:0] prod, nterm;
  logic               fsel;
  logic [7:0]         n;
  logic               qneg;
  logic [31:0]        ud;
  logic [63:0]        dvd;
  logic [32:0]        rem;
  logic [6:0]         cnt;

  logic signed [31:0] res_root;
  logic [1:0]         res_status;
  logic [7:0]         res_used;

  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] qprod;
  logic signed [35:0] cub_sum;
  logic signed [32:0] den_sum;
  logic signed [64:0] num_diff;
  logic signed [63:0] num;
  logic [32:0]        r_sh;
  logic               r_ge;
  logic signed [31:0] x3_next;
  logic signed [32:0] step;
  logic [32:0]        step_abs;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);

  // Shared multiplier operand select
  always_comb begin
    case (state)
      S_CSQ:   begin mul_a = cx; mul_b = cx; end
      S_CMUL:  begin mul_a = sq; mul_b = cx; end
      S_NUM1:  begin mul_a = f2; mul_b = x1; end
      S_NUM2:  begin mul_a = f1; mul_b = x2; end
      default: begin mul_a = cx; mul_b = cx; end
    endcase
  end

  // Datapath helpers
  always_comb begin
    qprod    = scrf_pkg::sat32(prod >>> FRAC_BITS);
    cub_sum  = 36'(qprod) - (36'(cx) <<< 1) - FIVE_Q;
    den_sum  = 33'(f2) - 33'(f1);
    num_diff = 65'(nterm) - 65'(prod);
    if (num_diff > 65'(64'sh7FFF_FFFF_FFFF_FFFF)) begin
      num = 64'sh7FFF_FFFF_FFFF_FFFF;
    end else if (num_diff < -65'sh1_0000_0000_0000_0000 + 65'sh0_8000_0000_0000_0000) begin
      num = 64'sh8000_0000_0000_0000;
    end else begin
      num = num_diff[63:0];
    end
    r_sh = {rem[31:0], dvd[63]};
    r_ge = (r_sh >= {1'b0, ud});
    // saturate signed quotient
    if (qneg) begin
      x3_next = (dvd > 64'h0000_0000_8000_0000) ? 32'sh8000_0000 : 32'(-$signed(dvd));
    end else begin
      x3_next = (dvd > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : dvd[31:0];
    end
    step     = 33'(x3_next) - 33'(x2);
    step_abs = step[32] ? 33'(-step) : 33'(step);
  end

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_axis_tvalid   <= 1'b0;
      tolerance       <= scrf_pkg::TOL_RESET;
      iteration_limit <= scrf_pkg::LIMIT_RESET;
    end else begin
      // S_DONE reloads the output register itself
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) m_axis_tvalid <= 1'b0;

      if (cfg_valid) begin
        if (cfg_index == scrf_pkg::REG_TOLERANCE) begin
          tolerance <= cfg_data[scrf_pkg::TOL_W-1:0];
        end else if (cfg_index == scrf_pkg::REG_ITER_LIMIT) begin
          iteration_limit <= cfg_data[scrf_pkg::LIMIT_W-1:0];
        end
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            x1   <= s_axis_tdata[31:0];
            x2   <= s_axis_tdata[63:32];
            cx   <= s_axis_tdata[31:0];
            fsel <= 1'b0;
            n    <= 8'd1;
            if (iteration_limit == '0) begin
              res_root   <= '0;
              res_status <= scrf_pkg::STATUS_LIMIT;
              res_used   <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_CSQ;
            end
          end
        end
        S_CSQ: begin
          prod  <= mul_a * mul_b;
          state <= S_CCU;
        end
        S_CCU: begin
          sq    <= qprod;
          state <= S_CMUL;
        end
        S_CMUL: begin
          prod  <= mul_a * mul_b;
          state <= S_CFIN;
        end
        S_CFIN: begin
          if (!fsel) begin
            f1    <= scrf_pkg::sat32(64'(cub_sum));
            cx    <= x2;
            fsel  <= 1'b1;
            state <= S_CSQ;
          end else begin
            f2    <= scrf_pkg::sat32(64'(cub_sum));
            state <= S_ITER;
          end
        end
        S_ITER: begin
          den <= scrf_pkg::sat32(64'(den_sum));
          if (den_sum == '0) begin
            res_root   <= '0;
            res_status <= scrf_pkg::STATUS_ZERO_DEN;
            res_used   <= n;
            state      <= S_DONE;
          end else begin
            state <= S_NUM1;
          end
        end
        S_NUM1: begin
          prod  <= mul_a * mul_b;
          state <= S_NUM2;
        end
        S_NUM2: begin
          nterm <= prod;
          prod  <= mul_a * mul_b;
          state <= S_NUM3;
        end
        S_NUM3: begin
          // set up magnitude division
          qneg  <= num[63] != den[31];
          dvd   <= num[63] ? 64'(-num) : 64'(num);
          ud    <= den[31] ? 32'(-den) : 32'(den);
          rem   <= '0;
          cnt   <= 7'd64;
          state <= S_DIV;
        end
        S_DIV: begin
          rem   <= r_ge ? (r_sh - {1'b0, ud}) : r_sh;
          dvd   <= {dvd[62:0], r_ge};
          cnt   <= cnt - 7'd1;
          if (cnt == 7'd1) state <= S_DFIN;
        end
        S_DFIN: begin
          if (step_abs < {2'b00, tolerance}) begin
            res_root   <= x3_next;
            res_status <= scrf_pkg::STATUS_CONVERGED;
            res_used   <= n;
            state      <= S_DONE;
          end else if (n == iteration_limit) begin
            res_root   <= x3_next;
            res_status <= scrf_pkg::STATUS_LIMIT;
            res_used   <= iteration_limit;
            state      <= S_DONE;
          end else begin
            // shift the secant window, then evaluate f at the new estimate
            x1    <= x2;
            x2    <= x3_next;
            f1    <= f2;
            cx    <= x3_next;
            n     <= n + 8'd1;
            state <= S_CSQ;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {6'd0, res_used, res_status, res_root};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
